// ----- sv/pixel_hit_stream_decoder_top_macros.svh -----
// assertion macros for the pixel hit stream decoder
// expects signals clk and rst_n in the module that uses them
`ifndef PIXEL_HIT_STREAM_DECODER_TOP_MACROS_SVH
`define PIXEL_HIT_STREAM_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PHSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phsd assertion failed");

// next-cycle implication, disabled while in reset
`define PHSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phsd assertion failed");

`endif

// ----- sv/phsd_pkg.sv -----
// shared types and codes of the pixel hit stream decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package phsd_pkg;

    // word kinds by lead byte
    localparam logic [3:0] KIND_IDLE    = 4'd0;
    localparam logic [3:0] KIND_HEADER  = 4'd3;
    localparam logic [3:0] KIND_TRAILER = 4'd4;
    localparam logic [3:0] KIND_EMPTY   = 4'd5;
    localparam logic [3:0] KIND_REGION  = 4'd6;
    localparam logic [3:0] KIND_SHORT   = 4'd7;
    localparam logic [3:0] KIND_LONG    = 4'd8;
    localparam logic [3:0] KIND_UNKNOWN = 4'd15;

    // event errors
    localparam logic [3:0] ERR_NONE            = 4'd0;
    localparam logic [3:0] ERR_TRAILER_EARLY   = 4'd1;
    localparam logic [3:0] ERR_TRAILER_LATE    = 4'd2;
    localparam logic [3:0] ERR_REGION_EARLY    = 4'd3;
    localparam logic [3:0] ERR_DATA_EARLY      = 4'd4;
    localparam logic [3:0] ERR_UNKNOWN_BYTE    = 4'd5;
    localparam logic [3:0] ERR_UNFINISHED      = 4'd6;
    localparam logic [3:0] ERR_NOT_STARTED     = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED       = 4'd8;

    // hit flags
    localparam logic [1:0] FLAG_OK        = 2'd0;
    localparam logic [1:0] FLAG_STUCK     = 2'd1;
    localparam logic [1:0] FLAG_BAD_CHIP  = 2'd2;
    localparam logic [1:0] FLAG_BAD_COORD = 2'd3;

    // result kinds
    localparam logic RES_HIT    = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_CHIP_ID   = 2'd0;
    localparam logic [1:0] CFG_RESCUE_BAD_CHIP_ID = 2'd1;

    localparam logic [4:0]  CHIP_NONE   = 5'd16;
    localparam logic [5:0]  REGION_NONE = 6'd32;
    localparam logic [10:0] ADDR_MAX    = 11'd1023;

    // command from front to back: optional data word, optional end of event
    typedef struct packed {
        logic       has_data;
        logic       after_hdr;
        logic [3:0] dcol;
        logic [9:0] base;
        logic [6:0] hitmap;
        logic [4:0] chip;
        logic [7:0] bunch;
        logic [5:0] region;
        logic       eoe;
        logic [3:0] err;
        logic [3:0] tflags;
    } cmd_t;

    // one result record
    typedef struct packed {
        logic        kind;
        logic [4:0]  chip;
        logic [7:0]  bunch;
        logic [5:0]  region;
        logic [3:0]  dcol;
        logic [10:0] addr;
        logic [1:0]  flag;
        logic [3:0]  err;
        logic [3:0]  tflags;
        logic        ok;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/phsd_fifo.sv -----
// small register queue with count, used between decoder parts
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module phsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/phsd_front.sv -----
// front part: word assembly, classification and event sequencing
// depends on phsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module phsd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     stream_byte,
    input  wire logic           end_of_event,
    input  wire logic [3:0]     expected_chip_id,
    input  wire logic           rescue_bad_chip_id,
    output phsd_pkg::cmd_t      cmd,
    output logic                cmd_push
);

    import phsd_pkg::*;

    logic [15:0] word_reg, word_next;
    logic [1:0]  pend_reg, pend_next;
    logic [3:0]  kind_reg, kind_next;
    logic        started_reg, started_next;
    logic        finished_reg, finished_next;
    logic        ach_reg, ach_next;
    logic [4:0]  chip_reg, chip_next;
    logic [7:0]  bunch_reg, bunch_next;
    logic [5:0]  region_reg, region_next;
    logic [3:0]  tflags_reg, tflags_next;
    logic [3:0]  error_reg, error_next;

    logic [7:0]  b;
    logic [3:0]  lead_kind;
    logic [3:0]  id;
    logic [7:0]  chip_lead;
    logic        data_done;
    logic [7:0]  b0, b1;
    logic [6:0]  hitmap;
    logic [3:0]  eoe_err;

    assign b = stream_byte;

    // lead byte classes
    always_comb
    begin
        if (b inside {8'hff, 8'hf1, 8'hf0})
            lead_kind = KIND_IDLE;
        else if (b[7:4] == 4'ha)
            lead_kind = KIND_HEADER;
        else if (b[7:4] == 4'hb)
            lead_kind = KIND_TRAILER;
        else if (b[7:4] == 4'he)
            lead_kind = KIND_EMPTY;
        else if (b[7:5] == 3'b110)
            lead_kind = KIND_REGION;
        else if (b[7:6] == 2'b01)
            lead_kind = KIND_SHORT;
        else if (b[7:6] == 2'b00)
            lead_kind = KIND_LONG;
        else
            lead_kind = KIND_UNKNOWN;
    end

    // header chip id with optional rescue
    assign chip_lead = word_reg[7:0];
    always_comb
    begin
        id = chip_lead[3:0];
        if (id != expected_chip_id && rescue_bad_chip_id)
            id = expected_chip_id;
    end

    always_comb
    begin
        word_next     = word_reg;
        pend_next     = pend_reg;
        kind_next     = kind_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        ach_next      = ach_reg;
        chip_next     = chip_reg;
        bunch_next    = bunch_reg;
        region_next   = region_reg;
        tflags_next   = tflags_reg;
        error_next    = error_reg;
        data_done     = 1'b0;
        b0            = word_reg[7:0];
        b1            = b;
        hitmap        = '0;

        if (error_reg == ERR_NONE)
        begin
            if (pend_reg == 2'd2)
            begin
                word_next = {word_reg[7:0], b};
                pend_next = 2'd1;
            end
            else if (pend_reg != 2'd0)
            begin
                pend_next = 2'd0;
                case (kind_reg)
                    KIND_HEADER:
                    begin
                        started_next  = 1'b1;
                        finished_next = 1'b0;
                        bunch_next    = b;
                        chip_next     = {1'b0, id};
                        ach_next      = 1'b1;
                    end
                    KIND_EMPTY:
                    begin
                        started_next  = 1'b1;
                        bunch_next    = b;
                        chip_next     = {1'b0, id};
                        finished_next = 1'b1;
                    end
                    KIND_SHORT:
                    begin
                        data_done = 1'b1;
                        ach_next  = 1'b0;
                    end
                    KIND_LONG:
                    begin
                        data_done = 1'b1;
                        ach_next  = 1'b0;
                        b0        = word_reg[15:8];
                        b1        = word_reg[7:0];
                        hitmap    = b[6:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                kind_next = lead_kind;
                case (lead_kind)
                    KIND_UNKNOWN:
                        error_next = ERR_UNKNOWN_BYTE;
                    KIND_TRAILER:
                    begin
                        if (!started_reg)
                            error_next = ERR_TRAILER_EARLY;
                        else if (finished_reg)
                            error_next = ERR_TRAILER_LATE;
                        else
                        begin
                            tflags_next   = b[3:0];
                            finished_next = 1'b1;
                            chip_next     = CHIP_NONE;
                        end
                    end
                    KIND_REGION:
                    begin
                        if (!started_reg)
                            error_next = ERR_REGION_EARLY;
                        else
                        begin
                            region_next = {1'b0, b[4:0]};
                            ach_next    = 1'b0;
                        end
                    end
                    KIND_HEADER, KIND_EMPTY:
                    begin
                        word_next = {8'h00, b};
                        pend_next = 2'd1;
                    end
                    KIND_SHORT, KIND_LONG:
                    begin
                        if (!started_reg)
                            error_next = ERR_DATA_EARLY;
                        else
                        begin
                            word_next = {8'h00, b};
                            pend_next = (lead_kind == KIND_LONG) ? 2'd2 : 2'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // status error, worked out from the state after this byte
        eoe_err = error_next;
        if (eoe_err == ERR_NONE && pend_next != 2'd0)
            eoe_err = ERR_TRUNCATED;
        if (eoe_err == ERR_NONE && !started_next)
            eoe_err = ERR_NOT_STARTED;
        if (eoe_err == ERR_NONE && !finished_next)
            eoe_err = ERR_UNFINISHED;
    end

    always_comb
    begin
        cmd.has_data  = data_done;
        cmd.after_hdr = ach_reg;
        cmd.dcol      = b0[5:2];
        cmd.base      = {b0[1:0], b1};
        cmd.hitmap    = hitmap;
        cmd.chip      = chip_next;
        cmd.bunch     = bunch_next;
        cmd.region    = region_next;
        cmd.eoe       = end_of_event;
        cmd.err       = eoe_err;
        cmd.tflags    = tflags_next;
    end

    assign cmd_push = accept && (data_done || end_of_event);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg     <= '0;
            pend_reg     <= '0;
            kind_reg     <= KIND_UNKNOWN;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            ach_reg      <= 1'b0;
            chip_reg     <= CHIP_NONE;
            bunch_reg    <= '0;
            region_reg   <= REGION_NONE;
            tflags_reg   <= '0;
            error_reg    <= ERR_NONE;
        end
        else if (accept && end_of_event)
        begin
            // event over: back to the idle state
            word_reg     <= '0;
            pend_reg     <= '0;
            kind_reg     <= KIND_UNKNOWN;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            ach_reg      <= 1'b0;
            chip_reg     <= CHIP_NONE;
            bunch_reg    <= '0;
            region_reg   <= REGION_NONE;
            tflags_reg   <= '0;
            error_reg    <= ERR_NONE;
        end
        else if (accept)
        begin
            word_reg     <= word_next;
            pend_reg     <= pend_next;
            kind_reg     <= kind_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
            ach_reg      <= ach_next;
            chip_reg     <= chip_next;
            bunch_reg    <= bunch_next;
            region_reg   <= region_next;
            tflags_reg   <= tflags_next;
            error_reg    <= error_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/phsd_back.sv -----
// back part: hit expansion, stuck check with held hit, status records
// depends on phsd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_hit_stream_decoder_top_macros.svh"

module phsd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire phsd_pkg::cmd_t cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    input  wire logic [3:0]     expected_chip_id,
    output phsd_pkg::res_t      res,
    output logic                res_wr,
    input  wire logic           res_full
);

    import phsd_pkg::*;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_MORE   = 2'd1;
    localparam logic [1:0] PH_FLUSH  = 2'd2;
    localparam logic [1:0] PH_STATUS = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  off_reg, off_next;
    logic [6:0]  rem_reg, rem_next;
    logic        held_valid_reg, held_valid_next;
    logic        corrupt_reg, corrupt_next;
    logic [4:0]  held_chip_reg;
    logic [7:0]  held_bunch_reg;
    logic [5:0]  held_region_reg;
    logic [3:0]  held_dcol_reg;
    logic [10:0] held_addr_reg;
    logic [1:0]  held_flag_reg;
    logic        load_held;

    logic        go, do_hit, do_flush;
    logic [2:0]  off;
    logic [6:0]  rem;
    logic [2:0]  low_idx;
    logic [10:0] addr;
    logic        stuck;
    logic [1:0]  flag;
    res_t        held_res, status_res;

    assign go       = cmd_valid && !res_full;
    assign do_hit   = (phase_reg == PH_START && cmd.has_data) || phase_reg == PH_MORE;
    assign do_flush = (phase_reg == PH_START && !cmd.has_data) || phase_reg == PH_FLUSH;
    assign off      = (phase_reg == PH_START) ? 3'd0 : off_reg;
    assign rem      = (phase_reg == PH_START) ? cmd.hitmap : rem_reg;
    assign addr     = 11'(cmd.base) + 11'(off);

    // lowest remaining hitmap bit
    always_comb
    begin
        low_idx = '0;
        for (int i = 6; i >= 0; i--)
        begin
            if (rem[i])
                low_idx = 3'(i);
        end
    end

    always_comb
    begin
        stuck = held_valid_reg && !cmd.after_hdr && held_region_reg == cmd.region &&
                held_dcol_reg == cmd.dcol && addr <= held_addr_reg;
        flag = FLAG_OK;
        if (cmd.region == REGION_NONE || addr > ADDR_MAX)
            flag = FLAG_BAD_COORD;
        if (stuck)
            flag = FLAG_STUCK;
        if (cmd.chip != {1'b0, expected_chip_id})
            flag = FLAG_BAD_CHIP;
    end

    always_comb
    begin
        held_res.kind   = RES_HIT;
        held_res.chip   = held_chip_reg;
        held_res.bunch  = held_bunch_reg;
        held_res.region = held_region_reg;
        held_res.dcol   = held_dcol_reg;
        held_res.addr   = held_addr_reg;
        held_res.flag   = (do_hit && stuck) ? FLAG_STUCK : held_flag_reg;
        held_res.err    = ERR_NONE;
        held_res.tflags = '0;
        held_res.ok     = 1'b0;
        held_res.last   = do_hit && rem == '0 && !cmd.eoe;

        status_res.kind   = RES_STATUS;
        status_res.chip   = cmd.chip;
        status_res.bunch  = cmd.bunch;
        status_res.region = cmd.region;
        status_res.dcol   = '0;
        status_res.addr   = '0;
        status_res.flag   = FLAG_OK;
        status_res.err    = cmd.err;
        status_res.tflags = cmd.tflags;
        status_res.ok     = (cmd.err == ERR_NONE) && !corrupt_reg;
        status_res.last   = 1'b1;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        off_next        = off_reg;
        rem_next        = rem_reg;
        held_valid_next = held_valid_reg;
        corrupt_next    = corrupt_reg;
        load_held       = 1'b0;
        cmd_pop         = 1'b0;
        res_wr          = 1'b0;
        res             = held_res;

        if (go)
        begin
            if (do_hit)
            begin
                res_wr          = held_valid_reg;
                load_held       = 1'b1;
                held_valid_next = 1'b1;
                if (flag != FLAG_OK)
                    corrupt_next = 1'b1;
                if (rem != '0)
                begin
                    phase_next = PH_MORE;
                    off_next   = low_idx + 3'd1;
                    rem_next   = rem & (rem - 7'd1);
                end
                else if (cmd.eoe)
                    phase_next = PH_FLUSH;
                else
                begin
                    phase_next = PH_START;
                    cmd_pop    = 1'b1;
                end
            end
            else if (do_flush)
            begin
                res_wr = 1'b1;
                if (held_valid_reg)
                begin
                    held_valid_next = 1'b0;
                    phase_next      = PH_STATUS;
                end
                else
                begin
                    res          = status_res;
                    corrupt_next = 1'b0;
                    phase_next   = PH_START;
                    cmd_pop      = 1'b1;
                end
            end
            else
            begin
                res             = status_res;
                res_wr          = 1'b1;
                held_valid_next = 1'b0;
                corrupt_next    = 1'b0;
                phase_next      = PH_START;
                cmd_pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            off_reg        <= '0;
            rem_reg        <= '0;
            held_valid_reg <= 1'b0;
            corrupt_reg    <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            off_reg        <= off_next;
            rem_reg        <= rem_next;
            held_valid_reg <= held_valid_next;
            corrupt_reg    <= corrupt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_held)
        begin
            held_chip_reg   <= cmd.chip;
            held_bunch_reg  <= cmd.bunch;
            held_region_reg <= cmd.region;
            held_dcol_reg   <= cmd.dcol;
            held_addr_reg   <= addr;
            held_flag_reg   <= flag;
        end
    end

    // a later hit of a word always has a held hit in front of it
    `PHSD_ASSERT_IMP(a_more_has_held, phase_reg == PH_MORE, held_valid_reg && off_reg != 3'd0)
    // the flush step leaves nothing held before the status record
    `PHSD_ASSERT_IMP(a_status_no_held, phase_reg == PH_STATUS, !held_valid_reg)
    // no record is written into a full result queue
    `PHSD_ASSERT_IMP(a_no_write_full, res_wr, !res_full)
    // after a status record the event's marks are gone
    `PHSD_ASSERT_NXT(a_status_clears, res_wr && res.kind == RES_STATUS,
                     !held_valid_reg && !corrupt_reg)

endmodule

`default_nettype wire

// ----- sv/pixel_hit_stream_decoder_top.sv -----
// a byte that completes a data word or ends an event is pushed into the command queue, where
// the back reads it; its results pass through the result queue before they can be popped
// throughput: one byte a cycle into the front while the command queue has room; the back
// writes the hits of a data word one after another, up to eight for a long word, and ends an
// event with a flush of any held hit and a status record; the hit expander in the back sets the sustained rate
// reset: rst_n asynchronous, active low; clears queues, event state and configuration
`timescale 1ns / 1ps
`default_nettype none

module pixel_hit_stream_decoder_top #(
    parameter int CMD_DEPTH = 4,    // command queue between front and back
    parameter int OUT_DEPTH = 2     // result queue on the output side
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte stream in
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  stream_byte,
    input  wire logic        end_of_event,
    // results out
    output logic             empty,
    input  wire logic        pop,
    output logic             result_kind,
    output logic [4:0]       chip_id,
    output logic [7:0]       bunch_counter,
    output logic [5:0]       region,
    output logic [3:0]       double_column,
    output logic [10:0]      pixel_address,
    output logic [1:0]       hit_flag,
    output logic [3:0]       event_error,
    output logic [3:0]       trailer_flags,
    output logic             event_ok,
    output logic             last_result,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);

    import phsd_pkg::*;

    // configuration registers
    logic [3:0] exp_chip_reg;
    logic       rescue_reg;

    // front to back command path
    cmd_t       front_cmd;
    logic       front_push;
    cmd_t       back_cmd;
    logic       cmd_full;
    logic       cmd_empty;
    logic       cmd_pop;
    logic       accept;

    // back to output queue
    res_t       back_res;
    logic       res_wr;
    logic       res_full;
    res_t       head_res;

    // the config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_chip_reg <= '0;
            rescue_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EXPECTED_CHIP_ID:   exp_chip_reg <= cfg_data;
                CFG_RESCUE_BAD_CHIP_ID: rescue_reg   <= cfg_data[0];
                default:
                begin
                    // writes to unused indexes are dropped
                end
            endcase
        end
    end

    // a byte is taken whenever the command queue has room, even if it
    // produces no command; only a full command queue holds the front back
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    phsd_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .stream_byte        (stream_byte),
        .end_of_event       (end_of_event),
        .expected_chip_id   (exp_chip_reg),
        .rescue_bad_chip_id (rescue_reg),
        .cmd                (front_cmd),
        .cmd_push           (front_push)
    );

    // decouples byte intake from hit expansion
    phsd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    // expands words into hits, holds one hit back for the stuck check,
    // flushes it and writes the status record at the end of an event
    phsd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (back_cmd),
        .cmd_valid        (!cmd_empty),
        .cmd_pop          (cmd_pop),
        .expected_chip_id (exp_chip_reg),
        .res              (back_res),
        .res_wr           (res_wr),
        .res_full         (res_full)
    );

    // output queue: the back keeps working while a result waits to be popped, until the queue is full
    phsd_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (head_res),
        .full    (res_full),
        .empty   (empty)
    );

    // oldest result on the ports
    assign result_kind   = head_res.kind;
    assign chip_id       = head_res.chip;
    assign bunch_counter = head_res.bunch;
    assign region        = head_res.region;
    assign double_column = head_res.dcol;
    assign pixel_address = head_res.addr;
    assign hit_flag      = head_res.flag;
    assign event_error   = head_res.err;
    assign trailer_flags = head_res.tflags;
    assign event_ok      = head_res.ok;
    assign last_result   = head_res.last;

endmodule

`default_nettype wire
